/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Command and status codes and the bitmap word geometry shared by the finder,
// the top level, the checker and the testbench.
package bfa_pkg;

  // Request commands.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  // Response status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Bitmap words are 64 frames wide, made of eight bytes of eight frames.
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;
  localparam int BYTE_BITS  = 8;
  localparam int BYTE_SEL_W = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

endpackage

/* rtl/bfa_if.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Valid/ready channels for requests, responses and the configuration write.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] frame_number;

  modport source (output valid, output cmd, output frame_number, input ready);
  modport sink   (input valid, input cmd, input frame_number, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] frame_out;
  logic [1:0]  status;

  modport source (output valid, output frame_out, output status, input ready);
  modport sink   (input valid, input frame_out, input status, output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds when not read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bfa_zero_find.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator lowest-zero finder
// Shared search unit: locates the lowest clear bit of an eight-bit vector.
// ----------------------------------------------------------------------------
module bfa_zero_find import bfa_pkg::*; (
  input  byte_t                 vec,
  output logic                  found,
  output logic [BYTE_SEL_W-1:0] idx
);

  // Priority search from bit 7 downward; the last clear bit seen, the lowest, wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        found = 1'b1;
        idx   = BYTE_SEL_W'(i);
      end
    end
  end

endmodule

/* rtl/bitmap_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit physical frame allocator over a used/free bitmap in RAM.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (cmd, frame_number); every request yields exactly
// one response on out_ch (frame_out, status). cfg_ch writes the number of
// kernel frames that a reserve request marks used; it is always ready.
// The bitmap lives in a RAM of 64-frame words, BITMAP_BYTES/8 words deep, rounded up.
// One request is handled at a time and in_ch.ready is low while it runs:
//   allocate: one word read per cycle in a linear word scan from word 0,
//             then the byte search, the frame search and the write back.
//   free:     read, write back, then the response.
//   reserve:  one write per fully reserved word, then a read and merge when
//             a partial word has to be merged, then the response.
//   unused command or out-of-range free: straight to the response.
// After reset a clearing pass writes zero to every word, and in_ch.ready
// stays low meanwhile.
// Responses go out through an output register; a stalled receiver holds the
// response and the next request may already be accepted, but that request
// does not complete until the held response is taken.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top import bfa_pkg::*; #(
  parameter int BITMAP_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  bfa_cfg_if.sink    cfg_ch,
  bfa_req_if.sink    in_ch,
  bfa_rsp_if.source  out_ch
);

  localparam int WORDS      = (BITMAP_BYTES + 7) / 8;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW         = AW + 1;
  localparam int TOTAL      = BITMAP_BYTES * 8;
  localparam int LAST_VALID = TOTAL - (WORDS - 1) * WORD_BITS;
  localparam word_t PAD_MASK = (LAST_VALID >= WORD_BITS) ? '0 :
                               ~((word_t'(1) << LAST_VALID) - word_t'(1));

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_FINDB, S_FINDK, S_FREE_WR, S_RSV, S_RSV_WR, S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [PW-1:0]         ptr_r, ptr_nxt;
  logic                  dval_r, dval_nxt;
  logic [AW-1:0]         daddr_r, daddr_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  word_t                 word_r, word_nxt;
  logic [BYTE_SEL_W-1:0] byte_r, byte_nxt;
  logic [5:0]            fn_r, fn_nxt;
  logic [15:0]           n_r, n_nxt;
  logic [15:0]           reserved_r, reserved_nxt;
  logic [14:0]           res_frame_r, res_frame_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [14:0]           out_frame_r, out_frame_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  word_t                 ram_wdata, ram_rdata;

  byte_t                 zf_vec, byte_full;
  logic                  zf_found;
  logic [BYTE_SEL_W-1:0] zf_idx;
  word_t                 scan_word;
  logic [31:0]           hit_frame;

  bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared search unit: first over byte-full flags, then inside the byte.
  always_comb begin
    for (int b = 0; b < WORD_BITS / BYTE_BITS; b++) begin
      byte_full[b] = &word_r[b*BYTE_BITS +: BYTE_BITS];
    end
    zf_vec = (state_r == S_FINDB) ? byte_full : word_r[byte_r*BYTE_BITS +: BYTE_BITS];
  end

  bfa_zero_find u_zf (
    .vec   (zf_vec),
    .found (zf_found),
    .idx   (zf_idx)
  );

  // The last word's frames beyond the bitmap count as used.
  assign scan_word  = ram_rdata | ((daddr_r == AW'(WORDS - 1)) ? PAD_MASK : '0);
  assign hit_frame  = 32'({addr_r, byte_r, zf_idx});

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.frame_out = out_frame_r;
  assign out_ch.status    = out_status_r;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    dval_nxt       = dval_r;
    daddr_nxt      = daddr_r;
    addr_nxt       = addr_r;
    word_nxt       = word_r;
    byte_nxt       = byte_r;
    fn_nxt         = fn_r;
    n_nxt          = n_r;
    reserved_nxt   = reserved_r;
    res_frame_nxt  = res_frame_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_frame_nxt  = out_frame_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r[AW-1:0];
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r[AW-1:0];

    // Configuration write.
    if (cfg_ch.valid) begin
      reserved_nxt = cfg_ch.data;
    end

    // A taken response frees the output register.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Clearing pass: zero one word per cycle.
      S_CLR: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + PW'(1);
        if (ptr_r == PW'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Accept a request and dispatch on the command.
      S_IDLE: begin
        if (in_ch.valid) begin
          res_frame_nxt  = '0;
          res_status_nxt = ST_OK;
          case (in_ch.cmd)
            CMD_ALLOC: begin
              ptr_nxt   = '0;
              dval_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            CMD_FREE: begin
              if (32'(in_ch.frame_number) >= 32'(TOTAL)) begin
                res_status_nxt = ST_INVALID;
                state_nxt      = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(32'(in_ch.frame_number) >> WORD_SHIFT);
                addr_nxt  = AW'(32'(in_ch.frame_number) >> WORD_SHIFT);
                fn_nxt    = in_ch.frame_number[5:0];
                state_nxt = S_FREE_WR;
              end
            end
            CMD_RESERVE: begin
              n_nxt     = (32'(reserved_r) > 32'(TOTAL)) ? 16'(TOTAL) : reserved_r;
              ptr_nxt   = '0;
              state_nxt = S_RSV;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Pipelined word scan: one read issued and one word checked per cycle.
      S_SCAN: begin
        if (dval_r && (scan_word != '1)) begin
          word_nxt  = scan_word;
          addr_nxt  = daddr_r;
          state_nxt = S_FINDB;
        end else if (dval_r && (daddr_r == AW'(WORDS - 1))) begin
          res_frame_nxt  = '0;
          res_status_nxt = ST_NONE;
          state_nxt      = S_RESP;
        end else if (ptr_r != PW'(WORDS)) begin
          ram_re    = 1'b1;
          ptr_nxt   = ptr_r + PW'(1);
          dval_nxt  = 1'b1;
          daddr_nxt = ptr_r[AW-1:0];
        end else begin
          dval_nxt = 1'b0;
        end
      end

      // Locate the first byte with a free frame.
      S_FINDB: begin
        byte_nxt  = zf_idx;
        state_nxt = S_FINDK;
      end

      // Locate the free frame in that byte and mark it used.
      S_FINDK: begin
        ram_we         = 1'b1;
        ram_waddr      = addr_r;
        ram_wdata      = word_r | (word_t'(1) << {byte_r, zf_idx});
        res_frame_nxt  = hit_frame[14:0];
        res_status_nxt = zf_found ? ST_OK : ST_NONE;
        state_nxt      = S_RESP;
      end

      // Clear the freed frame's bit.
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = ram_rdata & ~(word_t'(1) << fn_r);
        state_nxt = S_RESP;
      end

      // Reserve: whole words are written directly, a partial word is merged.
      S_RSV: begin
        if (32'(ptr_r) < 32'(n_r >> WORD_SHIFT)) begin
          ram_we    = 1'b1;
          ram_wdata = '1;
          ptr_nxt   = ptr_r + PW'(1);
        end else if (n_r[5:0] != 6'd0) begin
          ram_re    = 1'b1;
          addr_nxt  = ptr_r[AW-1:0];
          state_nxt = S_RSV_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RSV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = ram_rdata | ((word_t'(1) << n_r[5:0]) - word_t'(1));
        state_nxt = S_RESP;
      end

      // Hand the response to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = res_frame_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ptr_r       <= '0;
      dval_r      <= 1'b0;
      reserved_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      dval_r      <= dval_nxt;
      reserved_r  <= reserved_nxt;
      out_valid_r <= out_valid_nxt;
    end
    daddr_r      <= daddr_nxt;
    addr_r       <= addr_nxt;
    word_r       <= word_nxt;
    byte_r       <= byte_nxt;
    fn_r         <= fn_nxt;
    n_r          <= n_nxt;
    res_frame_r  <= res_frame_nxt;
    res_status_r <= res_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

/* rtl/bfa_checker.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic [14:0] out_frame,
  input logic [1:0]  out_status
);

  // Reset leaves no response pending and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_ready))
    else $error("response or ready seen right after reset");

  // One request at a time: ready drops after each accepted request.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  // Only defined status codes are returned.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NONE ||
                   out_status == ST_INVALID))
    else $error("undefined status code");

  // A failed request never carries a frame number.
  a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_frame == '0))
    else $error("frame number returned with an error status");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_frame  (out_ch.frame_out),
  .out_status (out_ch.status)
);

/* test/bitmap_frame_allocator_top_test.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives allocate, free, reserve and unused requests into the allocator,
// predicts every response from a frame-level copy of the used map, and
// checks each response field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top_test;
  import bfa_pkg::*;

  localparam int          BITMAP_BYTES = 4096;
  localparam int unsigned TOTAL_FRAMES = BITMAP_BYTES * 8;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 530;
  localparam int          MAX_REPORTS  = 10;
  localparam longint      RUN_LIMIT    = 64'd4 * 64'd4_000_000;

  typedef struct packed {
    logic [14:0] frame_out;
    logic [1:0]  status;
  } alloc_rsp_t;

  logic clk;
  logic rst_n;

  bfa_cfg_if cfg_ch ();
  bfa_req_if in_ch ();
  bfa_rsp_if out_ch ();

  bitmap_frame_allocator_top #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted state of the allocator.
  bit          frame_used [TOTAL_FRAMES];
  int unsigned lowest_maybe_free;
  logic [15:0] kernel_frames;

  // Responses still owed by the block, oldest first.
  alloc_rsp_t  owed_rsp_q[$];
  // Frames handed out by allocate requests, candidates for well-formed frees.
  int unsigned granted_frames[$];

  int unsigned mismatch_count;
  int unsigned rsp_checked;
  int unsigned req_count [4];
  int unsigned none_count;
  int unsigned invalid_count;

  bit          idle_on;
  bit          hold_pending;
  int unsigned hold_left;
  int unsigned stall_left;

  // Clock: period of 4 time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the response of one request and update the predicted used map.
  // Frame f is tracked directly; lowest_maybe_free bounds the first-fit scan.
  function automatic alloc_rsp_t predict_alloc_response(input logic [1:0]  cmd,
                                                        input logic [15:0] frame_number);
    alloc_rsp_t  rsp;
    int unsigned f;
    int unsigned n;
    rsp.frame_out = '0;
    rsp.status    = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        f = lowest_maybe_free;
        while (f < TOTAL_FRAMES && frame_used[f]) f++;
        lowest_maybe_free = f;
        if (f < TOTAL_FRAMES) begin
          frame_used[f]     = 1'b1;
          rsp.frame_out     = f[14:0];
          lowest_maybe_free = f + 1;
        end else begin
          rsp.status = ST_NONE;
        end
      end
      CMD_FREE: begin
        if (frame_number >= TOTAL_FRAMES) begin
          rsp.status = ST_INVALID;
        end else begin
          frame_used[frame_number] = 1'b0;
          if (frame_number < lowest_maybe_free) lowest_maybe_free = 32'(frame_number);
        end
      end
      CMD_RESERVE: begin
        // An oversized reservation covers the whole map and no more.
        n = 32'(kernel_frames);
        if (n > TOTAL_FRAMES) n = TOTAL_FRAMES;
        for (f = 0; f < n; f++) frame_used[f] = 1'b1;
        if (lowest_maybe_free < n) lowest_maybe_free = n;
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Compare one accepted response with the oldest one owed.
  task automatic check_response(input logic [14:0] frame_out, input logic [1:0] status);
    alloc_rsp_t want;
    rsp_checked++;
    if (owed_rsp_q.size() == 0) begin
      report_mismatch("response with no request outstanding", -1, int'(status));
    end else begin
      want = owed_rsp_q.pop_front();
      if (status !== want.status) begin
        report_mismatch("status", int'(want.status), int'(status));
      end
      if (frame_out !== want.frame_out) begin
        report_mismatch("frame_out", int'(want.frame_out), int'(frame_out));
      end
    end
  endtask

  // Response side: check every accepted response and drive ready, with
  // random stall bursts and an optional long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_response(out_ch.frame_out, out_ch.status);
    end
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one request, wait until it is taken, then predict its response.
  // The valid stays high on return so back-to-back requests need no gap.
  task automatic send_request(input logic [1:0] cmd, input logic [15:0] frame_number);
    alloc_rsp_t rsp;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.frame_number <= frame_number;
    do @(posedge clk); while (!in_ch.ready);
    rsp = predict_alloc_response(cmd, frame_number);
    owed_rsp_q.push_back(rsp);
    req_count[cmd]++;
    if (rsp.status == ST_NONE) none_count++;
    if (rsp.status == ST_INVALID) invalid_count++;
    if (cmd == CMD_ALLOC && rsp.status == ST_OK) granted_frames.push_back(32'(rsp.frame_out));
  endtask

  // Stop offering requests and wait until every owed response is back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (owed_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Write the kernel reservation size while the block is idle.
  task automatic write_kernel_frames(input logic [15:0] value);
    wait_for_drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid  <= 1'b0;
    kernel_frames = value;
  endtask

  // Basic behavior of each command on a fresh map, including frees of free
  // frames, out-of-range frees and the unused command code.
  task automatic test_basic_commands();
    send_request(CMD_ALLOC, 16'hFFFF);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_ALLOC, 16'h5A5A);
    send_request(CMD_FREE, 16'd1);
    send_request(CMD_ALLOC, 16'hA5A5);
    send_request(CMD_FREE, 16'd100);
    send_request(CMD_FREE, 16'd32768);
    send_request(CMD_FREE, 16'hFFFF);
    send_request(CMD_FREE, 16'h7FFF);
    send_request(CMD_UNUSED, 16'hFFFF);
    send_request(CMD_UNUSED, 16'h0000);
    send_request(CMD_RESERVE, 16'hFFFF);
    send_request(CMD_ALLOC, 16'h0000);
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the block fills up and drops its input ready.
  task automatic test_backpressure();
    int unsigned i;
    wait_for_drain();
    idle_on      = 1'b0;
    hold_pending = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_request((i % 3 == 2) ? CMD_FREE : CMD_ALLOC, 16'($urandom_range(0, 40)));
    end
    idle_on = 1'b1;
  endtask

  // A reservation marks the low frames used and leaves the frames above it,
  // both held and freed, as they were.
  task automatic test_reserve_keeps_upper();
    send_request(CMD_FREE, 16'd50);
    send_request(CMD_FREE, 16'd10);
    send_request(CMD_RESERVE, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
  endtask

  // Full map: allocate finds nothing, freed frames at both ends come back,
  // and an oversized reservation is clipped to the map.
  task automatic test_full_bitmap();
    write_kernel_frames(16'd32768);
    send_request(CMD_RESERVE, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd32767);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd16384);
    send_request(CMD_FREE, 16'd0);
    send_request(CMD_FREE, 16'd0);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd21845);
    write_kernel_frames(16'hFFFF);
    send_request(CMD_RESERVE, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
  endtask

  // Random traffic: mostly allocations and frees of granted frames, with
  // stray frees, out-of-range frees, reserves and unused commands mixed in.
  task automatic run_random_mix(input int unsigned count, input bit allow_idle);
    int unsigned i;
    int unsigned pick;
    int unsigned idx;
    logic [1:0]  cmd;
    logic [15:0] frame_number;
    for (i = 0; i < count; i++) begin
      idle_on      = allow_idle && (i % 128 < 96);
      pick         = $urandom_range(0, 99);
      frame_number = 16'($urandom);
      if (pick < 48) begin
        cmd = CMD_ALLOC;
      end else if (pick < 84) begin
        cmd = CMD_FREE;
        if (granted_frames.size() != 0) begin
          idx          = $urandom_range(0, granted_frames.size() - 1);
          frame_number = 16'(granted_frames[idx]);
          granted_frames.delete(idx);
        end
      end else if (pick < 91) begin
        cmd          = CMD_FREE;
        frame_number = 16'($urandom_range(0, 1023));
      end else if (pick < 95) begin
        cmd = CMD_FREE;
      end else if (pick < 98) begin
        cmd = CMD_RESERVE;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_request(cmd, frame_number);
    end
  endtask

  // Run limit in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_ALLOC;
    in_ch.frame_number = '0;
    out_ch.ready       = 1'b0;
    idle_on            = 1'b1;
    hold_pending       = 1'b0;
    hold_left          = 0;
    stall_left         = 0;
    mismatch_count     = 0;
    rsp_checked        = 0;
    none_count         = 0;
    invalid_count      = 0;
    req_count          = '{default: 0};
    lowest_maybe_free  = 0;
    kernel_frames      = '0;
    frame_used         = '{default: 1'b0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_kernel_frames(16'd0);
    test_basic_commands();
    test_backpressure();
    run_random_mix(330, 1'b1);

    write_kernel_frames(16'd37);
    test_reserve_keeps_upper();
    run_random_mix(290, 1'b1);

    write_kernel_frames(16'(20000 + $urandom_range(0, 999)));
    send_request(CMD_RESERVE, 16'h0000);
    run_random_mix(220, 1'b1);

    test_full_bitmap();
    run_random_mix(240, 1'b0);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d responses: %0d allocate, %0d free, %0d reserve, %0d unused.",
             rsp_checked, req_count[CMD_ALLOC], req_count[CMD_FREE],
             req_count[CMD_RESERVE], req_count[CMD_UNUSED]);
    $display("Map-full answers: %0d, invalid frame answers: %0d, mismatches: %0d.",
             none_count, invalid_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_ram.sv
rtl/bfa_zero_find.sv
rtl/bitmap_frame_allocator_top.sv
rtl/bfa_checker.sv
test/bitmap_frame_allocator_top_test.sv
